FILE: rtl/rsag_pkg.sv
// Ring slot address generator: shared types, command and operation codes.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rsag_pkg;

    localparam int ADDR_BITS = 17;
    localparam int CMD_BITS  = 4;
    localparam int WORD_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SETWR   = 4'd0,
        CMD_SETRD   = 4'd1,
        CMD_WR      = 4'd2,
        CMD_RD      = 4'd3,
        CMD_ZERO    = 4'd4,
        CMD_WRADV   = 4'd5,
        CMD_RDADV   = 4'd6,
        CMD_ZEROADV = 4'd7,
        CMD_WR1ADV  = 4'd8,
        CMD_RD1ADV  = 4'd9,
        CMD_CLEAR   = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_ZERO  = 2'd3
    } t_mem_op;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_END   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_VALID = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [ADDR_BITS-1:0] offset;
        logic [WORD_BITS-1:0] word_count;
        logic [WORD_BITS-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        t_mem_op              mem_op;
        logic [ADDR_BITS-1:0] mem_addr;
        logic [WORD_BITS-1:0] mem_words;
        logic [WORD_BITS-1:0] buffer_index;
        logic [WORD_BITS-1:0] data_word;
        logic                 accepted;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] slot_start;
        logic [ADDR_BITS-1:0] slot_end;
        logic                 slot_valid;
    } t_cfg;

    // Up to two results per command; res1 is meaningful only when two is set.
    typedef struct packed {
        t_out_item res0;
        t_out_item res1;
        logic      two;
    } t_exec_res;

endpackage

FILE: rtl/rsag_in_if.sv
// Command channel: valid/ready handshake carrying one command item.
// Depends on rsag_pkg.
`timescale 1ns / 1ps

interface rsag_in_if;
    import rsag_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/rsag_out_if.sv
// Result channel: valid/ready handshake carrying one memory transaction or status.
// Depends on rsag_pkg.
`timescale 1ns / 1ps

interface rsag_out_if;
    import rsag_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/rsag_exec.sv
// Command decode, bounds checks and ring address math; holds the two pointers.
// Depends on rsag_pkg.
`timescale 1ns / 1ps

module rsag_exec (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_commit,
    input  rsag_pkg::t_in_item        i_item,
    input  rsag_pkg::t_cfg            i_cfg,
    output rsag_pkg::t_exec_res       o_res
);
    import rsag_pkg::*;

    // Enough headroom for start + 2*offset + 2*count.
    localparam int XW = ADDR_BITS + 3;

    logic [ADDR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [ADDR_BITS-1:0] ptr_next;
    logic                 ptr_we, ptr_sel_rd;

    logic [WORD_BITS-1:0] n;
    logic [XW-1:0] x_start, x_end, x_off2, x_n2, x_cur, x_p;
    logic [XW-1:0] x_set, x_rand_a, x_rand_top, x_size;
    logic [XW-1:0] x_blk_top, x_blk_next, x_first, x_split_next;
    logic [XW-1:0] x_single_next, x_clr;
    logic [WORD_BITS-1:0] first_w, rest_w;
    logic          sel_rd, bad, gated, rej;
    t_mem_op       op;

    assign n       = i_item.word_count;
    assign x_start = XW'(i_cfg.slot_start);
    assign x_end   = XW'(i_cfg.slot_end);
    assign x_off2  = XW'({i_item.offset, 1'b0});
    assign x_n2    = XW'({n, 1'b0});

    assign sel_rd = (i_item.command == CMD_RDADV) || (i_item.command == CMD_RD1ADV);
    assign x_cur  = sel_rd ? XW'(r_rd_ptr) : XW'(r_wr_ptr);
    // Fall back to slot start when the pointer has left the slot
    assign x_p    = (x_cur < x_start || x_cur > x_end) ? x_start : x_cur;

    assign x_set       = x_start + XW'(i_item.offset);
    assign x_rand_a    = x_start + x_off2;
    assign x_rand_top  = x_rand_a + x_n2 - XW'(1);
    assign x_size      = x_end - x_start + XW'(1);
    assign x_blk_top   = x_p + x_n2 - XW'(1);
    assign x_blk_next  = x_p + x_n2;
    assign x_first     = (x_end - x_p + XW'(1)) >> 1;
    assign first_w     = x_first[WORD_BITS-1:0];
    assign rest_w      = n - first_w;
    assign x_split_next = x_start + XW'({rest_w, 1'b0});
    assign x_single_next = (x_p + XW'(1) < x_end) ? (x_p + XW'(2)) : x_start;
    assign x_clr       = x_size >> 1;

    assign gated = (i_item.command == CMD_WR)      || (i_item.command == CMD_ZERO)  ||
                   (i_item.command == CMD_WRADV)   || (i_item.command == CMD_RDADV) ||
                   (i_item.command == CMD_ZEROADV) || (i_item.command == CMD_WR1ADV) ||
                   (i_item.command == CMD_CLEAR);
    assign bad = (i_item.command > CMD_CLEAR) || (i_cfg.slot_start > i_cfg.slot_end) ||
                 (!i_cfg.slot_valid && gated);

    always_comb begin
        case (i_item.command)
            CMD_WR, CMD_WRADV, CMD_WR1ADV: op = OP_WRITE;
            CMD_RD, CMD_RDADV, CMD_RD1ADV: op = OP_READ;
            CMD_ZERO, CMD_ZEROADV, CMD_CLEAR: op = OP_ZERO;
            default: op = OP_NONE;
        endcase
    end

    always_comb begin
        o_res = '0;
        o_res.res0.mem_op   = OP_NONE;
        o_res.res1.mem_op   = OP_NONE;
        o_res.res0.accepted = 1'b1;
        o_res.res0.last     = 1'b1;
        rej        = bad;
        ptr_we     = 1'b0;
        ptr_sel_rd = 1'b0;
        ptr_next   = '0;
        if (!bad) begin
            case (i_item.command)
                CMD_SETWR, CMD_SETRD: begin
                    if (x_set > x_end) begin
                        rej = 1'b1;
                    end else begin
                        ptr_we     = 1'b1;
                        ptr_sel_rd = (i_item.command == CMD_SETRD);
                        ptr_next   = x_set[ADDR_BITS-1:0];
                    end
                end
                CMD_WR, CMD_RD, CMD_ZERO: begin
                    if (n != '0) begin
                        if (x_rand_top > x_end) begin
                            rej = 1'b1;
                        end else begin
                            o_res.res0.mem_op    = op;
                            o_res.res0.mem_addr  = x_rand_a[ADDR_BITS-1:0];
                            o_res.res0.mem_words = n;
                        end
                    end
                end
                CMD_WRADV, CMD_RDADV, CMD_ZEROADV: begin
                    if (n != '0) begin
                        if (x_n2 > x_size) begin
                            rej = 1'b1;
                        end else begin
                            ptr_we     = 1'b1;
                            ptr_sel_rd = sel_rd;
                            o_res.res0.mem_op   = op;
                            o_res.res0.mem_addr = x_p[ADDR_BITS-1:0];
                            if (x_blk_top <= x_end) begin
                                o_res.res0.mem_words = n;
                                ptr_next = (x_blk_next > x_end) ? x_start[ADDR_BITS-1:0]
                                                                : x_blk_next[ADDR_BITS-1:0];
                            end else begin
                                // Crosses the end: tail part restarts at slot start
                                o_res.res0.mem_words    = first_w;
                                o_res.res0.last         = 1'b0;
                                o_res.res1.mem_op       = op;
                                o_res.res1.mem_addr     = i_cfg.slot_start;
                                o_res.res1.mem_words    = rest_w;
                                o_res.res1.buffer_index = first_w;
                                o_res.res1.accepted     = 1'b1;
                                o_res.res1.last         = 1'b1;
                                o_res.two               = 1'b1;
                                ptr_next = (x_split_next > x_end) ? x_start[ADDR_BITS-1:0]
                                                                  : x_split_next[ADDR_BITS-1:0];
                            end
                        end
                    end
                end
                CMD_WR1ADV, CMD_RD1ADV: begin
                    ptr_we     = 1'b1;
                    ptr_sel_rd = sel_rd;
                    ptr_next   = x_single_next[ADDR_BITS-1:0];
                    o_res.res0.mem_op    = op;
                    o_res.res0.mem_addr  = x_p[ADDR_BITS-1:0];
                    o_res.res0.mem_words = WORD_BITS'(1);
                    o_res.res0.data_word = (i_item.command == CMD_WR1ADV) ?
                                           i_item.write_data : '0;
                end
                CMD_CLEAR: begin
                    o_res.res0.mem_op   = OP_ZERO;
                    o_res.res0.mem_addr = i_cfg.slot_start;
                    if (x_clr > XW'({WORD_BITS{1'b1}})) begin
                        // Full 64K-word slot: two halves of 32K words
                        o_res.res0.mem_words = {1'b1, {(WORD_BITS-1){1'b0}}};
                        o_res.res0.last      = 1'b0;
                        o_res.res1.mem_op    = OP_ZERO;
                        o_res.res1.mem_addr  = i_cfg.slot_start +
                                               {1'b1, {(ADDR_BITS-1){1'b0}}};
                        o_res.res1.mem_words = {1'b1, {(WORD_BITS-1){1'b0}}};
                        o_res.res1.accepted  = 1'b1;
                        o_res.res1.last      = 1'b1;
                        o_res.two            = 1'b1;
                    end else begin
                        o_res.res0.mem_words = x_clr[WORD_BITS-1:0];
                    end
                end
                default: rej = 1'b1;
            endcase
        end
        if (rej) begin
            o_res      = '0;
            o_res.res0.mem_op = OP_NONE;
            o_res.res1.mem_op = OP_NONE;
            o_res.res0.last   = 1'b1;
            ptr_we     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else if (i_commit && ptr_we) begin
            if (ptr_sel_rd) begin
                r_rd_ptr <= ptr_next;
            end else begin
                r_wr_ptr <= ptr_next;
            end
        end
    end

endmodule

FILE: rtl/rsag_result_buf.sv
// Two-entry result register: takes both results of a command at once and
// hands them out in order. Depends on rsag_pkg.
`timescale 1ns / 1ps

module rsag_result_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rsag_pkg::t_exec_res i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output rsag_pkg::t_out_item o_item
);
    import rsag_pkg::*;

    logic      r_v0, r_v1, n_v0, n_v1;
    t_out_item r_d0, r_d1, n_d0, n_d1;
    logic      take;

    assign take    = r_v0 && i_ready;
    // Free when empty, or when the only held result leaves this cycle
    assign o_free  = !r_v0 || (take && !r_v1);
    assign o_valid = r_v0;
    assign o_item  = r_d0;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (i_load) begin
            n_v0 = 1'b1;
            n_v1 = i_res.two;
            n_d0 = i_res.res0;
            n_d1 = i_res.res1;
        end else if (take) begin
            // advance the second result to the head
            n_v0 = r_v1;
            n_v1 = 1'b0;
            n_d0 = r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

endmodule

FILE: rtl/ring_slot_address_generator.sv
// Ring slot address generator top level: input register, config registers, execute
// logic and result buffer. Depends on rsag_pkg, the interfaces and both submodules.
// An accepted command item is held in the input register, then its results are loaded
// into the result buffer. Throughput: one item per cycle while results are taken; a
// wrapping block command or a full-slot clear gives two results, sent one by one.
// Reset (synchronous, active low): pointers 0, slot 0..131071, slot invalid.
`timescale 1ns / 1ps

module ring_slot_address_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rsag_in_if.sink                             i_cmd,
    rsag_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [rsag_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [rsag_pkg::ADDR_BITS-1:0]      i_cfg_data
);
    import rsag_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_cfg      r_cfg;
    t_exec_res exec_res;
    logic      buf_free, adv;

    assign adv         = r_in_valid && buf_free;
    assign i_cmd.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_item <= i_cmd.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_start <= '0;
            r_cfg.slot_end   <= '1;
            r_cfg.slot_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLOT_START: r_cfg.slot_start <= i_cfg_data;
                CFG_SLOT_END:   r_cfg.slot_end   <= i_cfg_data;
                CFG_SLOT_VALID: r_cfg.slot_valid <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rsag_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (adv),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_res    (exec_res)
    );

    rsag_result_buf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (exec_res),
        .o_free  (buf_free),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_item  (o_res.item)
    );

    // A non-final result is always an accepted memory transaction
    a_mid_is_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.item.last |->
            o_res.item.accepted && (o_res.item.mem_op != OP_NONE))
        else $error("non-final result is not a transaction");

    // A rejection is a single status result
    a_reject_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.item.accepted |->
            o_res.item.last && (o_res.item.mem_op == OP_NONE))
        else $error("rejected command with transaction or follow-up");

    // The second half of a split follows right after the first is taken
    a_split_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && !o_res.item.last |=> o_res.valid)
        else $error("second result missing after split");

    // A held command is neither lost nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_item))
        else $error("input register lost a pending item");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for ring_slot_address_generator: directed and random
// commands against an in-bench ring pointer predictor.
// Depends on rsag_pkg, rsag_in_if, rsag_out_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import rsag_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 42;
    localparam int RANDOM_PHASES = 16;
    localparam int MAX_SHOWN    = 10;
    localparam longint unsigned ADDR_TOP = 131071;
    localparam longint unsigned WORD_TOP = 65535;
    // Command codes the block does not define
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 4'd11;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [ADDR_BITS-1:0]    i_cfg_data;

    rsag_in_if  cmd_if();
    rsag_out_if res_if();

    ring_slot_address_generator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Ring predictor state: slot registers and both pointers
    longint unsigned ring_start = 0;
    longint unsigned ring_end   = ADDR_TOP;
    bit              ring_valid = 1'b0;
    longint unsigned wr_ptr     = 0;
    longint unsigned rd_ptr     = 0;

    t_out_item expected_txns[$];

    int error_count    = 0;
    int commands_sent  = 0;
    int results_seen   = 0;
    int split_results  = 0;
    int rejected_seen  = 0;
    int slot_settings  = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_off_left  = 0;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic t_mem_op mem_op_for(input t_cmd c);
        case (c)
            CMD_WR, CMD_WRADV, CMD_WR1ADV: return OP_WRITE;
            CMD_RD, CMD_RDADV, CMD_RD1ADV: return OP_READ;
            default:                       return OP_ZERO;
        endcase
    endfunction

    function automatic void push_txn(input t_mem_op op, input longint unsigned addr,
                                     input longint unsigned words, input longint unsigned idx,
                                     input longint unsigned data, input bit acc, input bit lst);
        t_out_item t;
        t.mem_op       = op;
        t.mem_addr     = addr[ADDR_BITS-1:0];
        t.mem_words    = words[WORD_BITS-1:0];
        t.buffer_index = idx[WORD_BITS-1:0];
        t.data_word    = data[WORD_BITS-1:0];
        t.accepted     = acc;
        t.last         = lst;
        expected_txns.push_back(t);
    endfunction

    function automatic void push_status(input bit acc);
        push_txn(OP_NONE, 0, 0, 0, 0, acc, 1'b1);
    endfunction

    // Work out the transactions one command causes and advance the pointers.
    function automatic void predict_command(input t_in_item it);
        longint unsigned off, n, p, a, span, head_words, tail_words;
        t_cmd c;
        bit gated;
        off = it.offset;
        n   = it.word_count;
        if (it.command > CMD_CLEAR || ring_start > ring_end) begin
            push_status(1'b0);
            return;
        end
        c = t_cmd'(it.command);
        gated = (c == CMD_WR) || (c == CMD_ZERO) || (c == CMD_WRADV) || (c == CMD_RDADV) ||
                (c == CMD_ZEROADV) || (c == CMD_WR1ADV) || (c == CMD_CLEAR);
        if (!ring_valid && gated) begin
            push_status(1'b0);
            return;
        end
        case (c)
            CMD_SETWR, CMD_SETRD: begin
                if (ring_start + off > ring_end) begin
                    push_status(1'b0);
                end else begin
                    if (c == CMD_SETWR) wr_ptr = (ring_start + off) & ADDR_TOP;
                    else rd_ptr = (ring_start + off) & ADDR_TOP;
                    push_status(1'b1);
                end
            end
            CMD_WR, CMD_RD, CMD_ZERO: begin
                a = ring_start + 2 * off;
                if (n == 0) push_status(1'b1);
                else if (a + 2 * n - 1 > ring_end) push_status(1'b0);
                else push_txn(mem_op_for(c), a, n, 0, 0, 1'b1, 1'b1);
            end
            CMD_WRADV, CMD_RDADV, CMD_ZEROADV: begin
                span = ring_end - ring_start + 1;
                if (n == 0) begin
                    push_status(1'b1);
                end else if (2 * n > span) begin
                    push_status(1'b0);
                end else begin
                    p = (c == CMD_RDADV) ? rd_ptr : wr_ptr;
                    if (p < ring_start || p > ring_end) p = ring_start;
                    if (p + 2 * n - 1 <= ring_end) begin
                        push_txn(mem_op_for(c), p, n, 0, 0, 1'b1, 1'b1);
                        p = p + 2 * n;
                    end else begin
                        // split at the end of the slot, restart at its start
                        head_words = (ring_end - p + 1) >> 1;
                        tail_words = n - head_words;
                        push_txn(mem_op_for(c), p, head_words, 0, 0, 1'b1, 1'b0);
                        push_txn(mem_op_for(c), ring_start, tail_words, head_words, 0,
                                 1'b1, 1'b1);
                        p = ring_start + 2 * tail_words;
                    end
                    if (p > ring_end) p = ring_start;
                    if (c == CMD_RDADV) rd_ptr = p & ADDR_TOP;
                    else wr_ptr = p & ADDR_TOP;
                end
            end
            CMD_WR1ADV, CMD_RD1ADV: begin
                p = (c == CMD_RD1ADV) ? rd_ptr : wr_ptr;
                if (p < ring_start || p > ring_end) p = ring_start;
                push_txn(mem_op_for(c), p, 1, 0, (c == CMD_WR1ADV) ? it.write_data : 0,
                         1'b1, 1'b1);
                if (p + 1 < ring_end) p = p + 2;
                else p = ring_start;
                if (c == CMD_RD1ADV) rd_ptr = p & ADDR_TOP;
                else wr_ptr = p & ADDR_TOP;
            end
            default: begin
                span = (ring_end - ring_start + 1) >> 1;
                if (span > WORD_TOP) begin
                    push_txn(OP_ZERO, ring_start, 32768, 0, 0, 1'b1, 1'b0);
                    push_txn(OP_ZERO, ring_start + 65536, span - 32768, 0, 0, 1'b1, 1'b1);
                end else begin
                    push_txn(OP_ZERO, ring_start, span, 0, 0, 1'b1, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
            note_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (got.last === 1'b0) split_results++;
        if (got.accepted === 1'b0) rejected_seen++;
        if (expected_txns.size() == 0) begin
            note_error($sformatf("unexpected result op=%0d addr=0x%0h words=%0d",
                                 got.mem_op, got.mem_addr, got.mem_words));
            return;
        end
        want = expected_txns.pop_front();
        check_field("mem_op",       want.mem_op,       got.mem_op);
        check_field("mem_addr",     want.mem_addr,     got.mem_addr);
        check_field("mem_words",    want.mem_words,    got.mem_words);
        check_field("buffer_index", want.buffer_index, got.buffer_index);
        check_field("data_word",    want.data_word,    got.data_word);
        check_field("accepted",     want.accepted,     got.accepted);
        check_field("last",         want.last,         got.last);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) check_result(res_if.item);
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            res_if.ready = 1'b0;
            hold_off_left--;
        end else begin
            res_if.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one item with random gaps; predict at the accepting edge.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.item  = it;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        predict_command(it);
        commands_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [CMD_BITS-1:0] command, input logic [ADDR_BITS-1:0] off,
                         input logic [WORD_BITS-1:0] n, input logic [WORD_BITS-1:0] data);
        t_in_item it;
        it.command    = command;
        it.offset     = off;
        it.word_count = n;
        it.write_data = data;
        send_item(it);
    endtask

    task automatic drain_results();
        cmd_if.valid = 1'b0;
        while (expected_txns.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Registers change only with the block idle.
    task automatic apply_slot(input longint unsigned s, input longint unsigned e, input bit v);
        drain_results();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_SLOT_START;
        i_cfg_data = s[ADDR_BITS-1:0];
        @(negedge i_clk);
        i_cfg_idx  = CFG_SLOT_END;
        i_cfg_data = e[ADDR_BITS-1:0];
        @(negedge i_clk);
        i_cfg_idx  = CFG_SLOT_VALID;
        i_cfg_data = {{(ADDR_BITS-1){1'b0}}, v};
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        ring_start = s;
        ring_end   = e;
        ring_valid = v;
        slot_settings++;
        repeat (2) @(negedge i_clk);
    endtask

    function automatic t_in_item random_command();
        t_in_item it;
        longint unsigned span, n;
        span = (ring_start <= ring_end) ? ring_end - ring_start + 1 : 64;
        if ($urandom_range(99) < 4)
            it.command = CMD_BITS'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        else it.command = CMD_BITS'($urandom_range(CMD_CLEAR, CMD_SETWR));
        it.write_data = WORD_BITS'($urandom);
        if ($urandom_range(9) == 0) it.offset = ADDR_BITS'($urandom);
        else if (it.command <= CMD_SETRD) it.offset = ADDR_BITS'($urandom_range(span));
        else it.offset = ADDR_BITS'($urandom_range(span / 2));
        case ($urandom_range(19))
            0:       n = 0;
            1, 2:    n = $urandom_range(WORD_TOP);
            3, 4:    n = $urandom_range(span / 2);
            default: n = $urandom_range(span / 4 + 1, 1);
        endcase
        if (n > WORD_TOP) n = WORD_TOP;
        it.word_count = n[WORD_BITS-1:0];
        return it;
    endfunction

    task automatic choose_random_slot();
        longint unsigned s, e;
        s = $urandom_range(ADDR_TOP);
        case ($urandom_range(9))
            0: begin
                s = 0;
                e = ADDR_TOP;
            end
            1: e = s;
            2: e = $urandom_range(ADDR_TOP);
            3: begin
                s = $urandom_range(ADDR_TOP, ADDR_TOP - 80);
                e = ADDR_TOP;
            end
            default: begin
                e = s + $urandom_range(255, 1);
                if (e > ADDR_TOP) e = ADDR_TOP;
            end
        endcase
        apply_slot(s, e, $urandom_range(7) != 0);
    endtask

    // Slot still invalid after reset: gated commands refused, reads allowed, undefined code refused.
    task automatic test_reset_state();
        issue(CMD_WR, 0, 1, 0);
        issue(CMD_RD, 0, 1, 0);
        issue(CMD_CLEAR, 0, 0, 0);
        issue(CMD_UNUSED_HI, 0, 0, 0);
    endtask

    // Whole address space: split clear, largest counts, wrap from the top.
    task automatic test_full_slot();
        apply_slot(0, ADDR_TOP, 1'b1);
        issue(CMD_SETWR, 17'h1FFFF, 0, 0);
        issue(CMD_CLEAR, 0, 0, 0);
        issue(CMD_ZERO, 0, 16'hFFFF, 0);
        issue(CMD_WR, 17'h1FFFF, 1, 0);
        // pointer on the last byte: empty first part, then the rest from the start
        issue(CMD_WRADV, 0, 16'hFFFF, 0);
        issue(CMD_WR1ADV, 0, 0, 16'hFFFF);
        issue(CMD_WR1ADV, 0, 0, 16'h0000);
    endtask

    // Small ring: wrapped blocks, exact-size block, oversize block, set bounds.
    task automatic test_ring_wrap();
        apply_slot(100, 131, 1'b1);
        issue(CMD_SETWR, 30, 0, 0);
        issue(CMD_WRADV, 0, 3, 0);
        issue(CMD_RDADV, 0, 16, 0);
        issue(CMD_RDADV, 0, 17, 0);
        issue(CMD_ZEROADV, 0, 0, 0);
        issue(CMD_SETRD, 32, 0, 0);
        issue(CMD_SETRD, 31, 0, 0);
        issue(CMD_RDADV, 0, 2, 0);
        issue(CMD_RD1ADV, 0, 0, 0);
        issue(CMD_WR, 15, 1, 0);
        issue(CMD_WR, 15, 2, 0);
    endtask

    // Inverted bounds refuse everything; an invalid slot refuses gated commands.
    task automatic test_bad_slot();
        apply_slot(200, 100, 1'b1);
        issue(CMD_SETWR, 0, 0, 0);
        issue(CMD_RD, 0, 1, 0);
        apply_slot(0, 63, 1'b0);
        issue(CMD_WRADV, 0, 2, 0);
        issue(CMD_ZERO, 0, 0, 0);
    endtask

    // Hold the receiver so the block fills and stalls, then pause for a drain.
    task automatic test_backpressure();
        apply_slot(0, 63, 1'b1);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_off_left  = HOLD_CYCLES;
        repeat (40) send_item(random_command());
        drain_results();
        repeat (5) send_item(random_command());
        drain_results();
        repeat (5) send_item(random_command());
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            choose_random_slot();
            case (ph % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin send_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            repeat (PHASE_ITEMS) send_item(random_command());
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.item  = '0;
        res_if.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_SLOT_START;
        i_cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_full_slot();
        test_ring_wrap();
        test_bad_slot();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (10) @(negedge i_clk);
        if (expected_txns.size() != 0)
            note_error($sformatf("%0d expected results never arrived", expected_txns.size()));

        $display("Checked %0d results (%0d split parts, %0d refusals) from %0d commands",
                 results_seen, split_results, rejected_seen, commands_sent);
        $display("over %0d slot settings, with input gaps, output stalls and a %0d-cycle hold",
                 slot_settings, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: ring_slot_address_generator.f
rtl/rsag_pkg.sv
rtl/rsag_in_if.sv
rtl/rsag_out_if.sv
rtl/rsag_exec.sv
rtl/rsag_result_buf.sv
rtl/ring_slot_address_generator.sv
sim/testbench.sv
